### src/link_command_frame_builder_macros.svh
`ifndef LINK_COMMAND_FRAME_BUILDER_MACROS_SVH
`define LINK_COMMAND_FRAME_BUILDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define LCFB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LCFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lcfb_pkg.sv
package lcfb_pkg;

    localparam int CELLS         = 12;
    localparam int PAYLOAD_BYTES = 9;

    localparam logic [8:0] HDR_CMD   = 9'h1FB;
    localparam logic [8:0] HDR_FAKE  = 9'h1F7;
    localparam logic [8:0] TAIL_SYM  = 9'h11C;
    localparam logic [7:0] READ_BYTE = 8'hFF;

    localparam logic [1:0] KIND_HEAD = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_SUM  = 2'd2;
    localparam logic [1:0] KIND_TAIL = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [8:0] sym;
    } cell_t;

    typedef struct packed {
        logic                              fake;
        logic [PAYLOAD_BYTES-1:0][7:0]     bytes;
    } frame_t;

endpackage

### src/lcfb_cell.sv
module lcfb_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  logic           shift,
    input  lcfb_pkg::cell_t load_cell,
    input  lcfb_pkg::cell_t up_cell,
    output lcfb_pkg::cell_t cell_out
);
    import lcfb_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;

    always_comb begin
        cell_next = cell_reg;
        if (load) begin
            cell_next = load_cell;
        end else if (shift) begin
            cell_next = up_cell;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg.kind <= cell_next.kind;
        cell_reg.sym  <= cell_next.sym;
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
    end

    assign cell_out = cell_reg;

endmodule

### src/lcfb_stage.sv
module lcfb_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic            release_frame,
    input  logic            action,
    input  logic            test_bit,
    input  logic [6:0]      telescope,
    input  logic            write_flag,
    input  logic [15:0]     reg_address,
    input  logic [31:0]     reg_data,
    input  logic [3:0]      trig_type,
    input  logic [3:0]      trig_count,
    input  logic [55:0]     trig_date,
    output logic            stage_valid,
    output lcfb_pkg::frame_t frame
);
    import lcfb_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;
    frame_t frame_next;

    always_comb begin
        frame_next.fake     = action;
        frame_next.bytes    = '0;
        frame_next.bytes[0] = {test_bit, telescope};
        if (!action) begin
            frame_next.bytes[1] = 8'h00;
            frame_next.bytes[2] = write_flag ? 8'h00 : READ_BYTE;
            frame_next.bytes[3] = reg_address[15:8];
            frame_next.bytes[4] = reg_address[7:0];
            frame_next.bytes[5] = reg_data[31:24];
            frame_next.bytes[6] = reg_data[23:16];
            frame_next.bytes[7] = reg_data[15:8];
            frame_next.bytes[8] = reg_data[7:0];
        end else begin
            frame_next.bytes[1] = {trig_type, trig_count};
            for (int i = 0; i < 7; i++) begin
                frame_next.bytes[2+i] = trig_date[55-8*i -: 8];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (release_frame) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_reg <= frame_next;
        end
    end

    assign stage_valid = valid_reg;
    assign frame       = frame_reg;

endmodule

### src/link_command_frame_builder.sv
// The first symbol of a frame is offered once its request transfer has passed the request register
// and then the parallel load of the cell chain.
// One symbol per cycle is shifted out of the cell chain while m_ready is high;
// the next request is held in the request register so frames run back to back.
// Reset (aresetn low, synchronous) empties the request register and the cell chain.
module link_command_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic        s_test_bit,
    input  logic [6:0]  s_telescope,
    input  logic        s_write_flag,
    input  logic [15:0] s_reg_address,
    input  logic [31:0] s_reg_data,
    input  logic [3:0]  s_trig_type,
    input  logic [3:0]  s_trig_count,
    input  logic [55:0] s_trig_date,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_symbol,
    output logic        m_last
);
    import lcfb_pkg::*;

    logic   stage_valid;
    frame_t frame;
    logic   accept;
    logic   shift;
    logic   load;
    cell_t  chain [CELLS];
    cell_t  load_cells [CELLS];
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    assign shift   = chain[0].valid && m_ready;
    assign load    = stage_valid && (!chain[0].valid || (shift && chain[0].kind == KIND_TAIL));
    assign s_ready = !stage_valid || load;
    assign accept  = s_valid && s_ready;

    lcfb_stage u_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .release_frame (load),
        .action        (s_action),
        .test_bit      (s_test_bit),
        .telescope     (s_telescope),
        .write_flag    (s_write_flag),
        .reg_address   (s_reg_address),
        .reg_data      (s_reg_data),
        .trig_type     (s_trig_type),
        .trig_count    (s_trig_count),
        .trig_date     (s_trig_date),
        .stage_valid   (stage_valid),
        .frame         (frame)
    );

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign load_cells[g] = '{valid: 1'b1, kind: KIND_HEAD,
                                     sym: frame.fake ? HDR_FAKE : HDR_CMD};
        end else if (g <= PAYLOAD_BYTES) begin : g_data
            assign load_cells[g] = '{valid: 1'b1, kind: KIND_DATA,
                                     sym: {1'b0, frame.bytes[g-1]}};
        end else if (g == CELLS - 2) begin : g_sum
            assign load_cells[g] = '{valid: 1'b1, kind: KIND_SUM, sym: 9'h000};
        end else begin : g_tail
            assign load_cells[g] = '{valid: 1'b1, kind: KIND_TAIL, sym: TAIL_SYM};
        end

        if (g == CELLS - 1) begin : g_top
            lcfb_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (load),
                .shift     (shift),
                .load_cell (load_cells[g]),
                .up_cell   ('0),
                .cell_out  (chain[g])
            );
        end else begin : g_mid
            lcfb_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (load),
                .shift     (shift),
                .load_cell (load_cells[g]),
                .up_cell   (chain[g+1]),
                .cell_out  (chain[g])
            );
        end
    end

    // running checksum of payload bytes as they leave the head cell
    always_comb begin
        sum_next = sum_reg;
        if (shift) begin
            case (chain[0].kind)
                KIND_HEAD: sum_next = 8'h00;
                KIND_DATA: sum_next = sum_reg + chain[0].sym[7:0];
                default:   sum_next = sum_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign m_valid  = chain[0].valid;
    assign m_symbol = (chain[0].kind == KIND_SUM) ? {1'b0, sum_reg} : chain[0].sym;
    assign m_last   = (chain[0].kind == KIND_TAIL);

endmodule

### src/lcfb_checker.sv
`include "link_command_frame_builder_macros.svh"

module lcfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [8:0] m_symbol,
    input logic       m_last
);
    import lcfb_pkg::*;

    `LCFB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_symbol) && $stable(m_last), "result stalled but changed")
    `LCFB_ASSERT_NOW(a_last_is_tail, aclk, aresetn, m_valid && m_last, m_symbol == TAIL_SYM, "last symbol is not the tail")
    `LCFB_ASSERT_NEXT(a_tail_then_header, aclk, aresetn, m_valid && m_ready && m_last, !m_valid || m_symbol == HDR_CMD || m_symbol == HDR_FAKE, "frame does not open with a header")
    `LCFB_ASSERT_NEXT(a_header_then_data, aclk, aresetn, m_valid && m_ready && !m_last && m_symbol[8], m_valid && !m_symbol[8] && !m_last, "header not followed by payload")

endmodule

bind link_command_frame_builder lcfb_checker u_lcfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_symbol (m_symbol),
    .m_last   (m_last)
);

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcfb_pkg::*;

    localparam int N_RANDOM    = 320;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 33;
    localparam int PRINT_CAP   = 40;

    typedef enum logic {
        FRAME_CMD  = 1'b0,
        FRAME_FAKE = 1'b1
    } frame_kind_e;

    typedef struct packed {
        frame_kind_e kind;
        logic        test_bit;
        logic [6:0]  telescope;
        logic        write_flag;
        logic [15:0] reg_address;
        logic [31:0] reg_data;
        logic [3:0]  trig_type;
        logic [3:0]  trig_count;
        logic [55:0] trig_date;
    } request_t;

    typedef logic [0:CELLS-1][8:0] frame_syms_t;

    typedef struct {
        logic [8:0] symbol;
        logic       last;
    } link_sym_t;

    typedef struct {
        request_t    req;
        bit          typed;
        frame_syms_t want;
    } stim_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_action      = 1'b0;
    logic        s_test_bit    = 1'b0;
    logic [6:0]  s_telescope   = '0;
    logic        s_write_flag  = 1'b0;
    logic [15:0] s_reg_address = '0;
    logic [31:0] s_reg_data    = '0;
    logic [3:0]  s_trig_type   = '0;
    logic [3:0]  s_trig_count  = '0;
    logic [55:0] s_trig_date   = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [8:0]  m_symbol;
    logic        m_last;

    link_sym_t pending_syms[$];
    int        err_count   = 0;
    int        cycle_count = 0;
    bit        steady      = 1'b0;
    int        hold_seq    = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;

    // first six rows have the whole expected frame typed in; other rows go through the frame builder below
    stim_row_t directed_rows [15] = '{
        '{'{FRAME_CMD, 1'b0, 7'h00, 1'b0, 16'h0000, 32'h0000_0000, 4'h0, 4'h0,
            56'h0}, 1'b1,
          '{9'h1FB, 9'h000, 9'h000, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h000,
            9'h000, 9'h000, 9'h0FF, 9'h11C}},
        '{'{FRAME_CMD, 1'b1, 7'h7F, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 4'hF,
            56'hFF_FFFF_FFFF_FFFF}, 1'b1,
          '{9'h1FB, 9'h0FF, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
            9'h0FF, 9'h0FF, 9'h0F9, 9'h11C}},
        '{'{FRAME_FAKE, 1'b0, 7'h00, 1'b0, 16'h0000, 32'h0000_0000, 4'h0, 4'h0,
            56'h0}, 1'b1,
          '{9'h1F7, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
            9'h000, 9'h000, 9'h000, 9'h11C}},
        '{'{FRAME_FAKE, 1'b1, 7'h7F, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 4'hF,
            56'hFF_FFFF_FFFF_FFFF}, 1'b1,
          '{9'h1F7, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
            9'h0FF, 9'h0FF, 9'h0F7, 9'h11C}},
        '{'{FRAME_CMD, 1'b1, 7'h00, 1'b0, 16'h0000, 32'h0000_0000, 4'h0, 4'h0,
            56'h0}, 1'b1,
          '{9'h1FB, 9'h080, 9'h000, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h000,
            9'h000, 9'h000, 9'h07F, 9'h11C}},
        '{'{FRAME_CMD, 1'b0, 7'h7F, 1'b1, 16'h0000, 32'h0000_0000, 4'h0, 4'h0,
            56'h0}, 1'b1,
          '{9'h1FB, 9'h07F, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
            9'h000, 9'h000, 9'h07F, 9'h11C}},
        '{'{FRAME_FAKE, 1'b0, 7'h12, 1'b0, 16'h0000, 32'h0000_0000, 4'hF, 4'h0,
            56'h0}, 1'b0, '0},
        '{'{FRAME_FAKE, 1'b0, 7'h21, 1'b0, 16'h0000, 32'h0000_0000, 4'h0, 4'hF,
            56'h01_0203_0405_0607}, 1'b0, '0},
        // payload bytes that look like control symbols once bit 8 is dropped
        '{'{FRAME_CMD, 1'b1, 7'h7B, 1'b0, 16'hFB1C, 32'hF7FB_1C00, 4'h0, 4'h0,
            56'h0}, 1'b0, '0},
        '{'{FRAME_FAKE, 1'b1, 7'h77, 1'b0, 16'h0000, 32'h0000_0000, 4'hF, 4'hB,
            56'h1C_FBF7_1CFB_F71C}, 1'b0, '0},
        // fields of the other frame kind must be ignored
        '{'{FRAME_CMD, 1'b0, 7'h33, 1'b1, 16'h1234, 32'h89AB_CDEF, 4'hA, 4'h5,
            56'hAA_AAAA_AAAA_AAAA}, 1'b0, '0},
        '{'{FRAME_FAKE, 1'b0, 7'h4C, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 4'h3, 4'hC,
            56'h5A_A55A_A55A_A55A}, 1'b0, '0},
        '{'{FRAME_CMD, 1'b0, 7'h55, 1'b0, 16'hAAAA, 32'h5555_5555, 4'h0, 4'h0,
            56'h0}, 1'b0, '0},
        '{'{FRAME_FAKE, 1'b1, 7'h2A, 1'b1, 16'h5555, 32'hAAAA_AAAA, 4'h5, 4'hA,
            56'h55_AA55_AA55_AA55}, 1'b0, '0},
        // checksum wraps to zero
        '{'{FRAME_CMD, 1'b0, 7'h01, 1'b1, 16'hFF00, 32'h0000_0000, 4'h0, 4'h0,
            56'h0}, 1'b0, '0}
    };

    link_command_frame_builder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_test_bit    (s_test_bit),
        .s_telescope   (s_telescope),
        .s_write_flag  (s_write_flag),
        .s_reg_address (s_reg_address),
        .s_reg_data    (s_reg_data),
        .s_trig_type   (s_trig_type),
        .s_trig_count  (s_trig_count),
        .s_trig_date   (s_trig_date),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_last        (m_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic frame_syms_t build_frame(input request_t r);
        frame_syms_t syms;
        logic [7:0]  payload [0:PAYLOAD_BYTES-1];
        logic [7:0]  csum;
        payload[0] = {r.test_bit, r.telescope};
        if (r.kind == FRAME_CMD) begin
            syms[0]    = HDR_CMD;
            payload[1] = 8'h00;
            payload[2] = r.write_flag ? 8'h00 : READ_BYTE;
            payload[3] = r.reg_address[15:8];
            payload[4] = r.reg_address[7:0];
            payload[5] = r.reg_data[31:24];
            payload[6] = r.reg_data[23:16];
            payload[7] = r.reg_data[15:8];
            payload[8] = r.reg_data[7:0];
        end else begin
            syms[0]    = HDR_FAKE;
            payload[1] = {r.trig_type, r.trig_count};
            for (int i = 0; i < 7; i++) begin
                payload[2 + i] = r.trig_date[55 - 8 * i -: 8];
            end
        end
        csum = 8'h00;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            syms[1 + k] = {1'b0, payload[k]};
            csum        = csum + payload[k];
        end
        syms[CELLS - 2] = {1'b0, csum};
        syms[CELLS - 1] = TAIL_SYM;
        return syms;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // offers one request, waits for its transfer, then queues the frame it must produce
    task automatic send_request(input request_t r, input frame_syms_t syms);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= r.kind;
        s_test_bit    <= r.test_bit;
        s_telescope   <= r.telescope;
        s_write_flag  <= r.write_flag;
        s_reg_address <= r.reg_address;
        s_reg_data    <= r.reg_data;
        s_trig_type   <= r.trig_type;
        s_trig_count  <= r.trig_count;
        s_trig_date   <= r.trig_date;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        for (int k = 0; k < CELLS; k++) begin
            pending_syms.push_back('{symbol: syms[k], last: (k == CELLS - 1)});
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        link_sym_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_syms.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, symbol %h", m_symbol));
            end else begin
                want = pending_syms.pop_front();
                if (m_symbol !== want.symbol) begin
                    report_mismatch($sformatf("symbol %h, expected %h", m_symbol, want.symbol));
                end
                if (m_last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b (symbol %h)",
                                              m_last, want.last, want.symbol));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout, %0d symbols outstanding", pending_syms.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        request_t    r;
        logic [63:0] wide;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req,
                         directed_rows[i].typed ? directed_rows[i].want
                                                : build_frame(directed_rows[i].req));
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 120) steady <= 1'b1;
            if (n == 180) steady <= 1'b0;
            // long receiver hold-off so the request register and cell chain fill up
            if (n == 220) hold_seq <= hold_seq + 1;
            wide          = {$urandom, $urandom};
            r.kind        = frame_kind_e'($urandom_range(1));
            r.test_bit    = 1'($urandom_range(1));
            r.telescope   = 7'($urandom_range(127));
            r.write_flag  = 1'($urandom_range(1));
            r.reg_address = 16'($urandom_range(65535));
            r.reg_data    = $urandom;
            r.trig_type   = 4'($urandom_range(15));
            r.trig_count  = 4'($urandom_range(15));
            r.trig_date   = wide[55:0];
            case ($urandom_range(7))
                0: begin
                    r.reg_data  = '1;
                    r.trig_date = '1;
                end
                1: begin
                    r.reg_data  = '0;
                    r.trig_date = '0;
                end
                default: begin
                end
            endcase
            send_request(r, build_frame(r));
        end
        s_valid <= 1'b0;

        while (pending_syms.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/lcfb_pkg.sv
src/lcfb_cell.sv
src/lcfb_stage.sv
src/link_command_frame_builder.sv
src/lcfb_checker.sv
sim/tb_top.sv
